/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HKB_ASSERT(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define HKB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HKB_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HKB_ASSERT(label, clk, rstn, expr)
`define HKB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HKB_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

/* src/hkb_pkg.sv */
// ----------------------------------------------------------------------------
// hkb_pkg
// Shared types, modifier masks and key translation tables.
// ----------------------------------------------------------------------------
package hkb_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_READ   = 1'b1
  } hkb_op_e;

  localparam logic [ByteW-1:0] ShiftMask = 8'h22;
  localparam logic [ByteW-1:0] SymMask   = 8'h44;
  localparam logic [ByteW-1:0] FnMask    = 8'h88;
  localparam logic [ByteW-1:0] CapsCode  = 8'h39;
  localparam logic [ByteW-1:0] NoByte    = 8'h00;

  localparam logic [ByteW-1:0] LetterFn [26] = '{
    8'd154, 8'd170, 8'd168, 8'd156, 8'd143, 8'd157, 8'd158, 8'd159, 8'd148,
    8'd160, 8'd161, 8'd162, 8'd172, 8'd171, 8'd149, 8'd150, 8'd141, 8'd144,
    8'd155, 8'd145, 8'd147, 8'd169, 8'd142, 8'd167, 8'd146, 8'd166
  };

  // zero where a letter has no symbol meaning
  localparam logic [ByteW-1:0] LetterSym [26] = '{
    8'd59,  8'd0,   8'd0,   8'd96,  8'd91,  8'd43,  8'd45,  8'd95,  8'd126,
    8'd61,  8'd63,  8'd0,   8'd0,   8'd0,   8'd39,  8'd34,  8'd123, 8'd93,
    8'd58,  8'd47,  8'd124, 8'd0,   8'd125, 8'd0,   8'd92,  8'd0
  };

  localparam logic [ByteW-1:0] DigitPlain [10] = '{
    8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48
  };

  localparam logic [ByteW-1:0] DigitShift [10] = '{
    8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42, 8'd40, 8'd41
  };

  // usage 0x2D..0x38; 0x32 unmapped
  localparam logic [ByteW-1:0] PunctPlain [12] = '{
    8'd45, 8'd61, 8'd91, 8'd93, 8'd92, 8'd0, 8'd59, 8'd39, 8'd96, 8'd44, 8'd46, 8'd47
  };

  localparam logic [ByteW-1:0] PunctShift [12] = '{
    8'd95, 8'd43, 8'd123, 8'd125, 8'd124, 8'd0, 8'd58, 8'd34, 8'd126, 8'd60, 8'd62, 8'd63
  };

endpackage

/* src/hkb_req_if.sv */
// ----------------------------------------------------------------------------
// hkb_req_if
// Request channel: keyboard report or host read.
// ----------------------------------------------------------------------------
interface hkb_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic                        report_ok;
  logic [hkb_pkg::ByteW-1:0]   modifiers;
  logic [hkb_pkg::ByteW-1:0]   key_code;

  modport source (output valid, operation, report_ok, modifiers, key_code, input ready);
  modport sink   (input valid, operation, report_ok, modifiers, key_code, output ready);
endinterface

/* src/hkb_rsp_if.sv */
// ----------------------------------------------------------------------------
// hkb_rsp_if
// Response channel: byte returned by a host read.
// ----------------------------------------------------------------------------
interface hkb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [hkb_pkg::ByteW-1:0]   read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink   (input valid, read_byte, output ready);
endinterface

/* src/hid_key_to_byte_bridge_unit.sv */
// Path: a host read is registered in the input stage, then the pending byte is loaded
//   into the result register, which drives it on rsp_o until the beat is handed off.
// Throughput: one beat per cycle on req_i, reports and reads alike; the only
//   stall is a read meeting a full, unaccepted result register.
// Caps lock and the pending byte update as the beat retires from the input stage.
// Reset (rst_ni low, async): caps lock off, nothing pending, both stages empty.
// ----------------------------------------------------------------------------
// hid_key_to_byte_bridge_unit
// Keyboard report to single-byte key bridge with a one-byte pending register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_key_to_byte_bridge_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  hkb_req_if.sink   req_i,
  hkb_rsp_if.source rsp_o
);

  // input stage
  logic                      s1_valid_q;
  logic                      s1_op_q;
  logic                      s1_ok_q;
  logic [hkb_pkg::ByteW-1:0] s1_mods_q;
  logic [hkb_pkg::ByteW-1:0] s1_code_q;

  // architectural state
  logic                      caps_q, caps_d;
  logic [hkb_pkg::ByteW-1:0] pend_q, pend_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic [hkb_pkg::ByteW-1:0] out_byte_q;

  logic                      req_fire;
  logic                      s1_adv;
  logic                      s1_read;
  logic                      s1_key;
  logic                      s1_take;
  logic                      s1_caps;
  logic                      out_free;
  logic [hkb_pkg::ByteW-1:0] xlat_byte;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign s1_read  = (s1_op_q == hkb_pkg::OP_READ);
  // reports never need the result register, so they retire unconditionally
  assign s1_adv   = s1_valid_q && (!s1_read || out_free);
  assign s1_key   = !s1_read && s1_ok_q && (s1_code_q != hkb_pkg::NoByte);
  // read retiring into the result register
  assign s1_take  = s1_adv && s1_read;
  assign s1_caps  = s1_key && (s1_code_q == hkb_pkg::CapsCode);

  assign req_i.ready     = !s1_valid_q || s1_adv;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_byte = out_byte_q;

  hkb_translate u_xlat (
    .code_i (s1_code_q),
    .mods_i (s1_mods_q),
    .caps_i (caps_q),
    .byte_o (xlat_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q   <= req_i.operation;
      s1_ok_q   <= req_i.report_ok;
      s1_mods_q <= req_i.modifiers;
      s1_code_q <= req_i.key_code;
    end
  end

  // state update: caps toggle, pending overwrite on nonzero byte, clear on read
  always_comb begin
    caps_d      = caps_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (s1_adv) begin
      if (s1_read) begin
        pend_d      = hkb_pkg::NoByte;
        out_valid_d = 1'b1;
      end else if (s1_key) begin
        if (s1_code_q == hkb_pkg::CapsCode) begin
          caps_d = !caps_q;
        end else if (xlat_byte != hkb_pkg::NoByte) begin
          pend_d = xlat_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q      <= 1'b0;
      pend_q      <= hkb_pkg::NoByte;
      out_valid_q <= 1'b0;
    end else begin
      caps_q      <= caps_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_byte_q <= pend_q;
    end
  end

  // a retired read always leaves nothing pending
  `HKB_ASSERT_NXT(a_read_clears, clk_i, rst_ni, s1_take, pend_q == hkb_pkg::NoByte)
  // a new result appears only after a read retires
  `HKB_ASSERT_IMP(a_rsp_from_read, clk_i, rst_ni, $rose(out_valid_q), $past(s1_take))
  // caps lock moves only on a caps-lock report
  `HKB_ASSERT_IMP(a_caps_src, clk_i, rst_ni, caps_q != $past(caps_q), $past(s1_adv && s1_caps))
  // a read never retires over a stalled result
  `HKB_ASSERT(a_no_overrun, clk_i, rst_ni, !(s1_take && out_valid_q && !rsp_o.ready))

endmodule

/* src/hkb_translate.sv */
// ----------------------------------------------------------------------------
// hkb_translate
// Usage code plus modifier layers to one key byte; zero means no mapping.
// ----------------------------------------------------------------------------
module hkb_translate (
  input  logic [hkb_pkg::ByteW-1:0] code_i,
  input  logic [hkb_pkg::ByteW-1:0] mods_i,
  input  logic                      caps_i,
  output logic [hkb_pkg::ByteW-1:0] byte_o
);

  logic                      shift_key;
  logic                      shift_let;
  logic                      sym;
  logic                      fn;
  logic [hkb_pkg::ByteW-1:0] let_off;
  logic [hkb_pkg::ByteW-1:0] fk_off;
  logic [4:0]                let_idx;
  logic [3:0]                dig_idx;
  logic [3:0]                pun_idx;

  assign shift_key = |(mods_i & hkb_pkg::ShiftMask);
  assign shift_let = shift_key ^ caps_i;
  assign sym       = |(mods_i & hkb_pkg::SymMask);
  assign fn        = |(mods_i & hkb_pkg::FnMask);

  assign let_off = code_i - 8'h04;
  assign fk_off  = code_i - 8'h3A;
  assign let_idx = let_off[4:0];
  // low nibble of code - 0x1E and code - 0x2D
  assign dig_idx = code_i[3:0] - 4'hE;
  assign pun_idx = code_i[3:0] - 4'hD;

  always_comb begin
    byte_o = hkb_pkg::NoByte;
    if (code_i >= 8'h04 && code_i <= 8'h1D) begin
      if (fn) begin
        byte_o = hkb_pkg::LetterFn[let_idx];
      end else if (sym) begin
        byte_o = hkb_pkg::LetterSym[let_idx];
      end else begin
        byte_o = (shift_let ? 8'd65 : 8'd97) + let_off;
      end
    end else if (code_i >= 8'h1E && code_i <= 8'h27) begin
      byte_o = shift_key ? hkb_pkg::DigitShift[dig_idx] : hkb_pkg::DigitPlain[dig_idx];
    end else if (code_i >= 8'h2D && code_i <= 8'h38) begin
      byte_o = shift_key ? hkb_pkg::PunctShift[pun_idx] : hkb_pkg::PunctPlain[pun_idx];
    end else if (code_i >= 8'h3A && code_i <= 8'h45) begin
      byte_o = 8'd129 + fk_off;  // F1..F12
    end else begin
      case (code_i)
        8'h28:   byte_o = 8'd13;
        8'h29:   byte_o = 8'd27;
        8'h2A:   byte_o = shift_key ? 8'd127 : 8'd8;
        8'h2B:   byte_o = 8'd9;
        8'h2C:   byte_o = 8'd32;
        8'h4A:   byte_o = 8'd152;
        8'h4B:   byte_o = 8'd153;
        8'h4C:   byte_o = 8'd127;
        8'h4D:   byte_o = 8'd165;
        8'h4E:   byte_o = 8'd164;
        8'h4F:   byte_o = fn ? 8'd165 : 8'd183;
        8'h50:   byte_o = fn ? 8'd152 : 8'd180;
        8'h51:   byte_o = fn ? 8'd164 : 8'd182;
        8'h52:   byte_o = fn ? 8'd153 : 8'd181;
        default: byte_o = hkb_pkg::NoByte;
      endcase
    end
  end

endmodule
